// ----- rtl/core/sm83x_pkg.sv -----
// sm83x_pkg: shared types, instruction codes and constants for the 0x2N row executor.
// Used by sm83x_front, sm83x_queue, sm83x_back and the top level. No dependencies.
`timescale 1ns / 1ps

package sm83x_pkg;

  // Low nibble of opcode 0x2N
  localparam logic [3:0] CMD_JR_NZ    = 4'h0;
  localparam logic [3:0] CMD_LD_HL_NN = 4'h1;
  localparam logic [3:0] CMD_LD_HLI_A = 4'h2;
  localparam logic [3:0] CMD_INC_HL   = 4'h3;
  localparam logic [3:0] CMD_INC_H    = 4'h4;
  localparam logic [3:0] CMD_DEC_H    = 4'h5;
  localparam logic [3:0] CMD_LD_H_N   = 4'h6;
  localparam logic [3:0] CMD_DAA      = 4'h7;
  localparam logic [3:0] CMD_JR_Z     = 4'h8;
  localparam logic [3:0] CMD_ADD_HL   = 4'h9;
  localparam logic [3:0] CMD_LD_A_HLI = 4'hA;
  localparam logic [3:0] CMD_DEC_HL   = 4'hB;
  localparam logic [3:0] CMD_INC_L    = 4'hC;
  localparam logic [3:0] CMD_DEC_L    = 4'hD;
  localparam logic [3:0] CMD_LD_L_N   = 4'hE;
  localparam logic [3:0] CMD_CPL      = 4'hF;

  // Flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // DAA corrections and limits
  localparam logic [7:0] DAA_LO_FIX = 8'h06;
  localparam logic [7:0] DAA_HI_FIX = 8'h60;
  localparam logic [7:0] DAA_HI_LIM = 8'h99;
  localparam logic [3:0] DAA_LO_LIM = 4'h9;

  // Cycle counts
  localparam logic [3:0] CYC_4  = 4'd4;
  localparam logic [3:0] CYC_8  = 4'd8;
  localparam logic [3:0] CYC_12 = 4'd12;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    OP_JR,
    OP_LD_HL_IMM,
    OP_ST_HLI,
    OP_INC_HL,
    OP_DEC_HL,
    OP_INC_R8,
    OP_DEC_R8,
    OP_LD_R8_IMM,
    OP_DAA,
    OP_ADD_HL,
    OP_LD_A_HLI,
    OP_CPL
  } op_kind_t;

  // Classified item, as held in the queue
  typedef struct packed {
    op_kind_t    kind;
    logic        sel_high;    // r8 ops: H when set, L when clear
    logic        jr_on_z;     // JR: taken on Z set when set, on Z clear when clear
    logic [1:0]  pc_len;      // instruction length in bytes
    logic [3:0]  base_cycles; // cycles when no branch is taken
    logic [7:0]  imm_byte;
    logic [15:0] imm_word;
    logic [7:0]  read_data;
  } dec_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

endpackage

// ----- rtl/core/sm83x_front.sv -----
// sm83x_front: classifies the command nibble into an operation kind and attributes.
// Depends on sm83x_pkg.
`timescale 1ns / 1ps

module sm83x_front (
  input  logic [3:0]        command,
  input  logic [7:0]        imm_byte,
  input  logic [15:0]       imm_word,
  input  logic [7:0]        read_data,
  output sm83x_pkg::dec_t   item
);

  always_comb begin
    item             = '0;
    item.imm_byte    = imm_byte;
    item.imm_word    = imm_word;
    item.read_data   = read_data;
    item.sel_high    = 1'b0;
    item.jr_on_z     = (command == sm83x_pkg::CMD_JR_Z);
    item.pc_len      = 2'd1;
    item.base_cycles = sm83x_pkg::CYC_8;
    item.kind        = sm83x_pkg::OP_CPL;
    unique case (command) inside
      sm83x_pkg::CMD_JR_NZ, sm83x_pkg::CMD_JR_Z: begin
        item.kind   = sm83x_pkg::OP_JR;
        item.pc_len = 2'd2;
      end
      sm83x_pkg::CMD_LD_HL_NN: begin
        item.kind        = sm83x_pkg::OP_LD_HL_IMM;
        item.pc_len      = 2'd3;
        item.base_cycles = sm83x_pkg::CYC_12;
      end
      sm83x_pkg::CMD_LD_HLI_A: item.kind = sm83x_pkg::OP_ST_HLI;
      sm83x_pkg::CMD_INC_HL:   item.kind = sm83x_pkg::OP_INC_HL;
      sm83x_pkg::CMD_DEC_HL:   item.kind = sm83x_pkg::OP_DEC_HL;
      sm83x_pkg::CMD_INC_H, sm83x_pkg::CMD_INC_L: begin
        item.kind        = sm83x_pkg::OP_INC_R8;
        item.sel_high    = (command == sm83x_pkg::CMD_INC_H);
        item.base_cycles = sm83x_pkg::CYC_4;
      end
      sm83x_pkg::CMD_DEC_H, sm83x_pkg::CMD_DEC_L: begin
        item.kind        = sm83x_pkg::OP_DEC_R8;
        item.sel_high    = (command == sm83x_pkg::CMD_DEC_H);
        item.base_cycles = sm83x_pkg::CYC_4;
      end
      sm83x_pkg::CMD_LD_H_N, sm83x_pkg::CMD_LD_L_N: begin
        item.kind     = sm83x_pkg::OP_LD_R8_IMM;
        item.sel_high = (command == sm83x_pkg::CMD_LD_H_N);
        item.pc_len   = 2'd2;
      end
      sm83x_pkg::CMD_DAA: begin
        item.kind        = sm83x_pkg::OP_DAA;
        item.base_cycles = sm83x_pkg::CYC_4;
      end
      sm83x_pkg::CMD_ADD_HL:   item.kind = sm83x_pkg::OP_ADD_HL;
      sm83x_pkg::CMD_LD_A_HLI: item.kind = sm83x_pkg::OP_LD_A_HLI;
      sm83x_pkg::CMD_CPL: begin
        item.kind        = sm83x_pkg::OP_CPL;
        item.base_cycles = sm83x_pkg::CYC_4;
      end
      default: item.kind = sm83x_pkg::OP_CPL;
    endcase
  end

endmodule

// ----- rtl/core/sm83x_queue.sv -----
// sm83x_queue: two-entry register queue of classified items between front and back.
// Depends on sm83x_pkg.
`timescale 1ns / 1ps

module sm83x_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  sm83x_pkg::dec_t               push_item,
  input  logic                          pop,
  output sm83x_pkg::dec_t               head,
  output sm83x_pkg::queue_status_t      status
);

  localparam int PTR_W = $clog2(sm83x_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(sm83x_pkg::QUEUE_DEPTH + 1);

  sm83x_pkg::dec_t    entries [sm83x_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign status.not_empty = (count != '0);
  assign status.full      = (count == CNT_W'(sm83x_pkg::QUEUE_DEPTH));
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign head             = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(sm83x_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_full_holds: assert property (@(posedge clk) disable iff (rst)
    (push && status.full && !do_pop) |=> status.full)
    else $error("push into full queue changed fill");

endmodule

// ----- rtl/core/sm83x_back.sv -----
// sm83x_back: executes classified items on A, HL, flags and PC; holds the result register.
// Depends on sm83x_pkg.
`timescale 1ns / 1ps

module sm83x_back (
  input  logic                      clk,
  input  logic                      rst,
  input  sm83x_pkg::dec_t           head,
  input  sm83x_pkg::queue_status_t  status,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                cycle_count,
  output logic                      write_enable,
  output logic [15:0]               mem_address,
  output logic [7:0]                write_data,
  output logic [7:0]                accum_out,
  output logic [15:0]               pair_out,
  output logic [3:0]                flags_out,
  output logic [15:0]               pc_out
);

  logic [7:0]  accumulator, accumulator_next;
  logic [15:0] pair_hl, pair_hl_next;
  logic [3:0]  flag_bits, flag_bits_next;
  logic [15:0] prog_counter, prog_counter_next;
  logic [3:0]  cycles;
  logic        we;

  logic [15:0] pc_seq;
  logic [15:0] jr_target;
  logic        jr_take;
  logic [7:0]  r8_in;
  logic [7:0]  r8_res;
  logic [7:0]  daa_corr;
  logic        f_z, f_n, f_h, f_c;

  // Take a new item whenever the result register is free or being drained
  assign pop = status.not_empty && (!out_valid || !out_stall);

  assign f_z = flag_bits[sm83x_pkg::FLAG_Z];
  assign f_n = flag_bits[sm83x_pkg::FLAG_N];
  assign f_h = flag_bits[sm83x_pkg::FLAG_H];
  assign f_c = flag_bits[sm83x_pkg::FLAG_C];

  assign pc_seq    = prog_counter + {14'd0, head.pc_len};
  assign jr_target = pc_seq + {{8{head.imm_byte[7]}}, head.imm_byte};
  assign jr_take   = head.jr_on_z ? f_z : !f_z;
  assign r8_in     = head.sel_high ? pair_hl[15:8] : pair_hl[7:0];

  always_comb begin
    daa_corr = f_c ? sm83x_pkg::DAA_HI_FIX : 8'd0;
    if (f_h || (!f_n && (accumulator[3:0] > sm83x_pkg::DAA_LO_LIM))) begin
      daa_corr = daa_corr | sm83x_pkg::DAA_LO_FIX;
    end
    if (f_c || (!f_n && (accumulator > sm83x_pkg::DAA_HI_LIM))) begin
      daa_corr = daa_corr | sm83x_pkg::DAA_HI_FIX;
    end
  end

  always_comb begin
    accumulator_next  = accumulator;
    pair_hl_next      = pair_hl;
    flag_bits_next    = flag_bits;
    prog_counter_next = pc_seq;
    cycles            = head.base_cycles;
    we                = 1'b0;
    r8_res            = r8_in;
    unique case (head.kind)
      sm83x_pkg::OP_JR: begin
        if (jr_take) begin
          prog_counter_next = jr_target;
          cycles            = sm83x_pkg::CYC_12;
        end
      end
      sm83x_pkg::OP_LD_HL_IMM: pair_hl_next = head.imm_word;
      sm83x_pkg::OP_ST_HLI: begin
        we           = 1'b1;
        pair_hl_next = pair_hl + 16'd1;
      end
      sm83x_pkg::OP_INC_HL: pair_hl_next = pair_hl + 16'd1;
      sm83x_pkg::OP_DEC_HL: pair_hl_next = pair_hl - 16'd1;
      sm83x_pkg::OP_INC_R8: begin
        r8_res         = r8_in + 8'd1;
        flag_bits_next = {(r8_res == 8'd0), 1'b0, (r8_in[3:0] == 4'hF), f_c};
        pair_hl_next   = head.sel_high ? {r8_res, pair_hl[7:0]} : {pair_hl[15:8], r8_res};
      end
      sm83x_pkg::OP_DEC_R8: begin
        r8_res         = r8_in - 8'd1;
        flag_bits_next = {(r8_res == 8'd0), 1'b1, (r8_in[3:0] == 4'h0), f_c};
        pair_hl_next   = head.sel_high ? {r8_res, pair_hl[7:0]} : {pair_hl[15:8], r8_res};
      end
      sm83x_pkg::OP_LD_R8_IMM: begin
        pair_hl_next = head.sel_high ? {head.imm_byte, pair_hl[7:0]}
                                     : {pair_hl[15:8], head.imm_byte};
      end
      sm83x_pkg::OP_DAA: begin
        accumulator_next = f_n ? (accumulator - daa_corr) : (accumulator + daa_corr);
        flag_bits_next   = {(accumulator_next == 8'd0), f_n, 1'b0, (f_c | daa_corr[6])};
      end
      sm83x_pkg::OP_ADD_HL: begin
        pair_hl_next   = {pair_hl[14:0], 1'b0};
        flag_bits_next = {f_z, 1'b0, pair_hl[11], pair_hl[15]};
      end
      sm83x_pkg::OP_LD_A_HLI: begin
        accumulator_next = head.read_data;
        pair_hl_next     = pair_hl + 16'd1;
      end
      sm83x_pkg::OP_CPL: begin
        accumulator_next = ~accumulator;
        flag_bits_next   = {f_z, 1'b1, 1'b1, f_c};
      end
      default: begin
        accumulator_next = accumulator;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= '0;
      pair_hl      <= '0;
      flag_bits    <= '0;
      prog_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        accumulator  <= accumulator_next;
        pair_hl      <= pair_hl_next;
        flag_bits    <= flag_bits_next;
        prog_counter <= prog_counter_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cycle_count  <= cycles;
      write_enable <= we;
      mem_address  <= pair_hl;
      write_data   <= we ? accumulator : 8'd0;
      accum_out    <= accumulator_next;
      pair_out     <= pair_hl_next;
      flags_out    <= flag_bits_next;
      pc_out       <= prog_counter_next;
    end
  end

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    pop |=> (pc_out == prog_counter) && (pair_out == pair_hl)
            && (accum_out == accumulator) && (flags_out == flag_bits))
    else $error("result register out of step with kept state");

  a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !pop)
    else $error("item taken while result register is held");

  a_write_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (write_data == 8'd0))
    else $error("write data set without a memory write");

  a_cycle_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((cycle_count == sm83x_pkg::CYC_4) || (cycle_count == sm83x_pkg::CYC_8)
                   || (cycle_count == sm83x_pkg::CYC_12)))
    else $error("illegal cycle count");

endmodule

// ----- rtl/core/sm83_opcode_row_2x_execute.sv -----
// sm83_opcode_row_2x_execute: top level of the opcode 0x20-0x2F row executor.
// Depends on sm83x_pkg, sm83x_front, sm83x_queue and sm83x_back.
`timescale 1ns / 1ps
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_stall  | command, imm_byte, imm_word, read_data
//  result   | out_valid / out_stall| cycle_count, write_enable, mem_address,
//           |                      | write_data, accum_out, pair_out, flags_out, pc_out
//
//  Sustains one item per clock while out_stall is low; each item yields exactly
//  one result. An accepted item is classified and written into the two-entry
//  queue, then executed against A, HL, flags and PC into the result register and
//  shown from then on; while the result register is held, it waits in the queue.
//  in_stall rises only when the queue is full; out_stall holds the result register
//  and, through it, the queue.
//  Synchronous reset clears A, HL, flags, PC and the queue; no clearing pass.

module sm83_opcode_row_2x_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  command,
  input  logic [7:0]  imm_byte,
  input  logic [15:0] imm_word,
  input  logic [7:0]  read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  cycle_count,
  output logic        write_enable,
  output logic [15:0] mem_address,
  output logic [7:0]  write_data,
  output logic [7:0]  accum_out,
  output logic [15:0] pair_out,
  output logic [3:0]  flags_out,
  output logic [15:0] pc_out
);

  sm83x_pkg::dec_t          front_item;
  sm83x_pkg::dec_t          head;
  sm83x_pkg::queue_status_t status;
  logic                     pop;

  // Classify the incoming command
  sm83x_front u_front (
    .command   (command),
    .imm_byte  (imm_byte),
    .imm_word  (imm_word),
    .read_data (read_data),
    .item      (front_item)
  );

  // Stall the input only while the queue has no free entry
  assign in_stall = status.full;

  sm83x_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  // Execute and hold the result until it is taken
  sm83x_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .status       (status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cycle_count  (cycle_count),
    .write_enable (write_enable),
    .mem_address  (mem_address),
    .write_data   (write_data),
    .accum_out    (accum_out),
    .pair_out     (pair_out),
    .flags_out    (flags_out),
    .pc_out       (pc_out)
  );

endmodule
